### sv/grid_ray_wall_caster_assert.svh
// assertion macros for the grid ray wall caster
`ifndef GRID_RAY_WALL_CASTER_ASSERT_SVH
`define GRID_RAY_WALL_CASTER_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define GRWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grwc assertion failed");

// next-cycle implication
`define GRWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grwc assertion failed");

`endif

### sv/grwc_pkg.sv
// package with shared constants, types and the colour table of the ray caster
package grwc_pkg;

    localparam int MAP_DIM_DEF   = 64;
    localparam int HEIGHT_CAP    = 2000;
    localparam logic [7:0] EMPTY_CELL = 8'h30;
    localparam logic [7:0] DARKEN     = 8'd20;
    localparam int DIV_W         = 32;
    localparam int DIVISOR_W     = 16;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MAP_ROWS      = 2'd0;
    localparam logic [1:0] REG_MAP_COLS      = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_LOAD,
        ST_WALK,
        ST_READ,
        ST_DIST,
        ST_DIVD,
        ST_HGT,
        ST_DIVH,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // wall colour by type byte, darkened on column side
    function automatic rgb_t wall_colour(input logic [7:0] wtype, input logic side);
        rgb_t c;
        case (wtype)
            8'h31:   c = '{blue: 8'd20,  green: 8'd150, red: 8'd50};
            8'h32:   c = '{blue: 8'd20,  green: 8'd50,  red: 8'd200};
            8'h33:   c = '{blue: 8'd150, green: 8'd20,  red: 8'd50};
            8'h34:   c = '{blue: 8'd55,  green: 8'd40,  red: 8'd40};
            8'h35:   c = '{blue: 8'd150, green: 8'd200, red: 8'd200};
            8'h36:   c = '{blue: 8'd168, green: 8'd168, red: 8'd60};
            8'h56:   c = '{blue: 8'd40,  green: 8'd168, red: 8'd170};
            default: c = '{blue: 8'd20,  green: 8'd20,  red: 8'd20};
        endcase
        if (side)
        begin
            c.red   = c.red - DARKEN;
            c.green = c.green - DARKEN;
            c.blue  = c.blue - DARKEN;
        end
        return c;
    endfunction

endpackage

### sv/grid_ray_wall_caster.sv
// grid dda ray caster: map store, cell walk sequencer and result stage
// cast sequence: init, origin read, a walk and a read step per cell crossed, final edge test,
// distance and height divisions (start, one step per quotient bit, done), then the output state
// a distance needing no division skips the distance divider; an origin outside the map goes straight to output
// a write request is taken in the idle state; one request in flight, next request accepted once
// the result is loaded; reset: rst_n async active low, rows 64, cols 64, height 600, map not cleared
module grid_ray_wall_caster
    import grwc_pkg::*;
#(
    parameter int MAP_DIM = MAP_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_row[5:0] cell_col[11:6] cell_type[19:12] pos_x[33:20] pos_y[47:34]
    // dir_x[63:48] dir_y[79:64]
    input  logic [79:0] s_tdata,
    // action[0]
    input  logic        s_tuser,
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit[0] side[1] wall_type[9:2] wall_distance[25:10] wall_height[36:26]
    // red[44:37] green[52:45] blue[60:53], zero [63:61]
    output logic [63:0] m_tdata
);

    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAP_DIM) + 2;
    localparam int NW    = LW + 16;
    localparam int ACC_W = 24 + $clog2(MAP_DIM);

    // configuration registers
    logic [6:0]  map_rows_reg, map_cols_reg;
    logic [10:0] screen_height_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_rows_reg      <= 7'd64;
            map_cols_reg      <= 7'd64;
            screen_height_reg <= 11'd600;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MAP_ROWS:      map_rows_reg      <= pwdata[6:0];
                REG_MAP_COLS:      map_cols_reg      <= pwdata[6:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_MAP_ROWS:      prdata = {25'd0, map_rows_reg};
            REG_MAP_COLS:      prdata = {25'd0, map_cols_reg};
            REG_SCREEN_HEIGHT: prdata = {21'd0, screen_height_reg};
            default:           prdata = '0;
        endcase
    end

    // rows and cols in use, clamped to 1..MAP_DIM
    logic [LW-1:0] rows_use, cols_use;
    assign rows_use = (map_rows_reg == 7'd0) ? LW'(1) :
                      ((32'(map_rows_reg) > MAP_DIM) ? LW'(MAP_DIM) : LW'(map_rows_reg));
    assign cols_use = (map_cols_reg == 7'd0) ? LW'(1) :
                      ((32'(map_cols_reg) > MAP_DIM) ? LW'(MAP_DIM) : LW'(map_cols_reg));

    // request fields
    logic [5:0]  in_cell_row, in_cell_col;
    logic [7:0]  in_cell_type;
    logic [13:0] in_pos_x, in_pos_y;
    logic [15:0] in_dir_x, in_dir_y;
    assign in_cell_row  = s_tdata[5:0];
    assign in_cell_col  = s_tdata[11:6];
    assign in_cell_type = s_tdata[19:12];
    assign in_pos_x     = s_tdata[33:20];
    assign in_pos_y     = s_tdata[47:34];
    assign in_dir_x     = s_tdata[63:48];
    assign in_dir_y     = s_tdata[79:64];

    state_t state_reg, state_next;

    // walk state
    logic [13:0]      px_reg, py_reg;
    logic             neg_x_reg, neg_y_reg;
    logic [15:0]      ax_reg, ay_reg;
    logic [LW-1:0]    cx_reg, cy_reg;
    logic [ACC_W-1:0] accx_reg, accy_reg;
    logic             side_reg, hit_reg, zero_reg;
    logic [7:0]       type_reg;
    logic [15:0]      dq_reg;
    logic [10:0]      h_reg;
    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;

    logic in_acc, out_free, origin_out;
    logic row_edge, col_edge;
    logic step_row;
    logic [LW-1:0] ncx, ncy;
    logic [8:0] fx, fy;
    logic signed [NW-1:0] num;
    logic num_neg, dir_zero, dir_neg;
    logic [DIV_W-1:0] mag;

    // ram and divider
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]  ram_rdata;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    grwc_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(in_cell_type),
        .rdata(ram_rdata)
    );

    grwc_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    assign in_acc     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign origin_out = (32'(in_pos_x[13:8]) >= 32'(rows_use)) ||
                        (32'(in_pos_y[13:8]) >= 32'(cols_use));

    // edge test and step choice
    assign row_edge = neg_x_reg ? (cx_reg == '0) : ((cx_reg + 1'b1) >= rows_use);
    assign col_edge = neg_y_reg ? (cy_reg == '0) : ((cy_reg + 1'b1) >= cols_use);
    assign step_row = accx_reg < accy_reg;
    assign ncx      = neg_x_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
    assign ncy      = neg_y_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
    assign fx       = neg_x_reg ? {1'b0, px_reg[7:0]} : 9'd256 - {1'b0, px_reg[7:0]};
    assign fy       = neg_y_reg ? {1'b0, py_reg[7:0]} : 9'd256 - {1'b0, py_reg[7:0]};

    // signed offset from origin to the crossed boundary
    always_comb
    begin
        if (side_reg)
        begin
            num = $signed(NW'(cy_reg) << 8) - $signed(NW'(py_reg))
                  + (neg_y_reg ? NW'(256) : NW'(0));
            dir_zero = (ay_reg == '0);
            dir_neg  = neg_y_reg;
        end
        else
        begin
            num = $signed(NW'(cx_reg) << 8) - $signed(NW'(px_reg))
                  + (neg_x_reg ? NW'(256) : NW'(0));
            dir_zero = (ax_reg == '0);
            dir_neg  = neg_x_reg;
        end
        num_neg = num[NW-1];
        mag     = num_neg ? DIV_W'(-num) : DIV_W'(num);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_tuser)
                begin
                    state_next = origin_out ? ST_PUSH : ST_INIT;
                end
            end
            ST_INIT: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_WALK;
            ST_WALK: state_next = (hit_reg || row_edge || col_edge) ? ST_DIST : ST_READ;
            ST_READ: state_next = ST_WALK;
            ST_DIST:
            begin
                if (dir_zero || num == '0 || (num_neg != dir_neg))
                begin
                    state_next = ST_HGT;
                end
                else
                begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: state_next = div_rsp.done ? ST_HGT : ST_DIVD;
            ST_HGT:  state_next = ST_DIVH;
            ST_DIVH: state_next = div_rsp.done ? ST_PUSH : ST_DIVH;
            ST_PUSH: state_next = out_free ? ST_IDLE : ST_PUSH;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake, ram port and divider requests
    always_comb
    begin
        s_tready         = (state_reg == ST_IDLE);
        ram_we           = 1'b0;
        ram_addr         = AW'(32'(in_cell_row) * MAP_DIM + 32'(in_cell_col));
        div_req.start    = 1'b0;
        div_req.dividend = mag << 14;
        div_req.divisor  = side_reg ? ay_reg : ax_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ram_we = in_acc && !s_tuser && (32'(in_cell_row) < MAP_DIM) &&
                         (32'(in_cell_col) < MAP_DIM);
            end
            ST_INIT:
            begin
                ram_addr = AW'(32'(cx_reg) * MAP_DIM + 32'(cy_reg));
            end
            ST_WALK:
            begin
                if (step_row)
                begin
                    ram_addr = AW'(32'(ncx) * MAP_DIM + 32'(cy_reg));
                end
                else
                begin
                    ram_addr = AW'(32'(cx_reg) * MAP_DIM + 32'(ncy));
                end
            end
            ST_DIST:
            begin
                div_req.start = !(dir_zero || num == '0 || (num_neg != dir_neg));
            end
            ST_HGT:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(screen_height_reg) << 8;
                div_req.divisor  = (dq_reg == '0) ? DIVISOR_W'(256) : dq_reg;
            end
            default: ;
        endcase
    end

    // walk datapath
    logic [13:0]      px_next, py_next;
    logic             neg_x_next, neg_y_next;
    logic [15:0]      ax_next, ay_next;
    logic [LW-1:0]    cx_next, cy_next;
    logic [ACC_W-1:0] accx_next, accy_next;
    logic             side_next, hit_next, zero_next;
    logic [7:0]       type_next;
    logic [15:0]      dq_next;
    logic [10:0]      h_next;
    logic             m_tvalid_next;
    logic [63:0]      m_tdata_next;
    rgb_t             rgb;

    always_comb
    begin
        px_next       = px_reg;
        py_next       = py_reg;
        neg_x_next    = neg_x_reg;
        neg_y_next    = neg_y_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        accx_next     = accx_reg;
        accy_next     = accy_reg;
        side_next     = side_reg;
        hit_next      = hit_reg;
        zero_next     = zero_reg;
        type_next     = type_reg;
        dq_next       = dq_reg;
        h_next        = h_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rgb           = wall_colour(type_reg, side_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_tuser)
                begin
                    px_next    = in_pos_x;
                    py_next    = in_pos_y;
                    neg_x_next = in_dir_x[15];
                    neg_y_next = in_dir_y[15];
                    ax_next    = in_dir_x[15] ? 16'(-in_dir_x) : in_dir_x;
                    ay_next    = in_dir_y[15] ? 16'(-in_dir_y) : in_dir_y;
                    cx_next    = LW'(in_pos_x[13:8]);
                    cy_next    = LW'(in_pos_y[13:8]);
                    side_next  = 1'b0;
                    hit_next   = 1'b0;
                    zero_next  = origin_out;
                    type_next  = '0;
                    dq_next    = '0;
                    h_next     = '0;
                end
            end
            ST_INIT:
            begin
                accx_next = ACC_W'(fx * ay_reg);
                accy_next = ACC_W'(fy * ax_reg);
            end
            ST_LOAD:
            begin
                type_next = ram_rdata;
            end
            ST_WALK:
            begin
                if (!(hit_reg || row_edge || col_edge))
                begin
                    if (step_row)
                    begin
                        side_next = 1'b0;
                        cx_next   = ncx;
                        accx_next = accx_reg + (ACC_W'(ay_reg) << 8);
                    end
                    else
                    begin
                        side_next = 1'b1;
                        cy_next   = ncy;
                        accy_next = accy_reg + (ACC_W'(ax_reg) << 8);
                    end
                end
            end
            ST_READ:
            begin
                type_next = ram_rdata;
                hit_next  = (ram_rdata != EMPTY_CELL);
            end
            ST_DIST:
            begin
                if (dir_zero)
                begin
                    dq_next = 16'hFFFF;
                end
                else if (num == '0 || (num_neg != dir_neg))
                begin
                    dq_next = '0;
                end
            end
            ST_DIVD:
            begin
                if (div_rsp.done)
                begin
                    dq_next = (div_rsp.quotient > DIV_W'(16'hFFFF)) ? 16'hFFFF
                                                                      : div_rsp.quotient[15:0];
                end
            end
            ST_DIVH:
            begin
                if (div_rsp.done)
                begin
                    h_next = (div_rsp.quotient > DIV_W'(HEIGHT_CAP)) ? 11'(HEIGHT_CAP)
                                                                      : div_rsp.quotient[10:0];
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    if (zero_reg)
                    begin
                        m_tdata_next = '0;
                    end
                    else
                    begin
                        m_tdata_next = {3'd0, rgb.blue, rgb.green, rgb.red, h_reg, dq_reg,
                                        type_reg, side_reg, hit_reg};
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        side_reg    <= side_next;
        hit_reg     <= hit_next;
        zero_reg    <= zero_next;
        type_reg    <= type_next;
        dq_reg      <= dq_next;
        h_reg       <= h_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### sv/grwc_ram.sv
// generic single-port synchronous ram with registered read
module grwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read before write, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### sv/grwc_div.sv
// iterative restoring divider, one quotient bit per cycle
module grwc_div
    import grwc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIVISOR_W:0]   rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   rem_shift;

    // one shift and trial subtract per cycle
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_shift = {rem_reg[DIVISOR_W-1:0], dvd_reg[DIV_W-1]};
        if (req.start)
        begin
            dvd_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = CW'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dsr_reg})
            begin
                rem_next = rem_shift - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

### sv/grwc_checker.sv
// port-level checks for the ray caster, bound to the top level
`include "grid_ray_wall_caster_assert.svh"

module grwc_checker
    import grwc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result stays offered
    `GRWC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // a stalled result keeps its bits
    `GRWC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

    // column height never exceeds the cap
    `GRWC_ASSERT_NOW(a_height_cap, m_tvalid, m_tdata[36:26] <= 11'(HEIGHT_CAP))

    // a hit always reports a wall type, never the empty cell
    `GRWC_ASSERT_NOW(a_hit_type, m_tvalid && m_tdata[0], m_tdata[9:2] != EMPTY_CELL)

endmodule

bind grid_ray_wall_caster grwc_checker u_grwc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
